@@ design/point_in_polygon_test_top_defines.svh @@
// ---------------------------------------------------------------------------
// point in polygon assertion macros
// concurrent assertion wrappers, empty in synthesis
// ---------------------------------------------------------------------------
`ifndef POINT_IN_POLYGON_TEST_TOP_DEFINES_SVH
`define POINT_IN_POLYGON_TEST_TOP_DEFINES_SVH
`ifndef SYNTHESIS
`define PIP_ASSERT(lbl, clk, rst, prop) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("pip assertion failed");
`define PIP_ASSERT_ALWAYS(lbl, clk, prop) \
  lbl: assert property (@(posedge clk) prop) else $error("pip assertion failed");
`else
`define PIP_ASSERT(lbl, clk, rst, prop)
`define PIP_ASSERT_ALWAYS(lbl, clk, prop)
`endif
`endif

@@ design/pip_pkg.sv @@
// ---------------------------------------------------------------------------
// pip_pkg
// shared types and codes of the point in polygon test
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
package pip_pkg;
  localparam logic [1:0] CMD_APPEND = 2'd0;
  localparam logic [1:0] CMD_QUERY  = 2'd1;
  localparam logic [1:0] CMD_CLEAR  = 2'd2;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_WALK,
    ST_DRAIN,
    ST_FINISH
  } state_t;

  // sequencer to edge unit
  typedef struct packed {
    logic start;
    logic take;
    logic first_take;
    logic close;
  } edge_ctl_t;
endpackage

@@ design/pip_in_if.sv @@
// ---------------------------------------------------------------------------
// pip_in_if
// input item channel: command and coordinates
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
interface pip_in_if #(parameter int COORD_WIDTH = 16);
  logic                          valid;
  logic                          ready;
  logic [1:0]                    command;
  logic signed [COORD_WIDTH-1:0] coord_x;
  logic signed [COORD_WIDTH-1:0] coord_y;
  modport source (output valid, command, coord_x, coord_y, input ready);
  modport sink (input valid, command, coord_x, coord_y, output ready);
endinterface

@@ design/pip_out_if.sv @@
// ---------------------------------------------------------------------------
// pip_out_if
// result item channel of a query
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
interface pip_out_if;
  logic valid;
  logic ready;
  logic inside_res;
  logic on_vertex;
  logic overflowed;
  modport source (output valid, inside_res, on_vertex, overflowed, input ready);
  modport sink (input valid, inside_res, on_vertex, overflowed, output ready);
endinterface

@@ design/pip_cell.sv @@
// ---------------------------------------------------------------------------
// pip_cell
// one vertex slot of the rotating chain
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
module pip_cell #(
  parameter int COORD_WIDTH = 16
) (
  input  logic                          clk,
  input  logic                          we,
  input  logic                          shift,
  input  logic                          wrap,
  input  logic signed [COORD_WIDTH-1:0] wx,
  input  logic signed [COORD_WIDTH-1:0] wy,
  input  logic signed [COORD_WIDTH-1:0] nx,
  input  logic signed [COORD_WIDTH-1:0] ny,
  input  logic signed [COORD_WIDTH-1:0] fx,
  input  logic signed [COORD_WIDTH-1:0] fy,
  output logic signed [COORD_WIDTH-1:0] x,
  output logic signed [COORD_WIDTH-1:0] y
);
  always_ff @(posedge clk) begin
    if (we) begin
      x <= wx;
      y <= wy;
    end else if (shift) begin
      // last live slot takes the head vertex, closing the ring
      x <= wrap ? fx : nx;
      y <= wrap ? fy : ny;
    end
  end
endmodule

@@ design/pip_edge.sv @@
// ---------------------------------------------------------------------------
// pip_edge
// pipelined edge crossing test and vertex match
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
module pip_edge #(
  parameter int COORD_WIDTH = 16
) (
  input  logic                          clk,
  input  pip_pkg::edge_ctl_t            ctl,
  input  logic signed [COORD_WIDTH-1:0] px,
  input  logic signed [COORD_WIDTH-1:0] py,
  input  logic signed [COORD_WIDTH-1:0] cx,
  input  logic signed [COORD_WIDTH-1:0] cy,
  output logic                          parity,
  output logic                          hit
);
  import pip_pkg::*;
  localparam int DW = COORD_WIDTH + 1;
  localparam int PW = 2 * DW;

  logic signed [COORD_WIDTH-1:0] prev_x, prev_y, first_x, first_y;
  logic signed [COORD_WIDTH-1:0] ex, ey;
  logic                          fire;
  logic signed [DW-1:0]          d_a, d_b, d_c, d_y;
  logic                          s1_valid, s1_pos;
  logic signed [PW-1:0]          lhs, rhs;
  logic                          s2_valid, s2_pos;

  assign ex   = ctl.close ? first_x : cx;
  assign ey   = ctl.close ? first_y : cy;
  assign fire = (ctl.take && !ctl.first_take) || ctl.close;

  always_ff @(posedge clk) begin
    if (ctl.take) begin
      prev_x <= cx;
      prev_y <= cy;
    end
    if (ctl.first_take) begin
      first_x <= cx;
      first_y <= cy;
    end
    // stage 1: differences and straddle
    s1_valid <= fire && ((ey > py) != (prev_y > py));
    d_a      <= DW'(px) - DW'(ex);
    d_b      <= DW'(prev_x) - DW'(ex);
    d_c      <= DW'(py) - DW'(ey);
    d_y      <= DW'(prev_y) - DW'(ey);
    s1_pos   <= prev_y > ey;
    // stage 2: cross products
    s2_valid <= s1_valid;
    s2_pos   <= s1_pos;
    lhs      <= PW'(d_a) * PW'(d_y);
    rhs      <= PW'(d_b) * PW'(d_c);
  end

  always_ff @(posedge clk) begin
    if (ctl.start) begin
      parity <= 1'b0;
      hit    <= 1'b0;
    end else begin
      if (ctl.take && cx == px && cy == py) hit <= 1'b1;
      if (s2_valid && (s2_pos ? (lhs < rhs) : (rhs < lhs))) parity <= !parity;
    end
  end
endmodule

@@ design/point_in_polygon_test_top.sv @@
// ---------------------------------------------------------------------------
// point_in_polygon_test_top
// crossing number point in polygon test over a rotating vertex chain
// ---------------------------------------------------------------------------
// append and clear are accepted only in the idle state
// a query walks the n stored vertices, the vertex ring
// rotating one vertex per cycle past a single three stage edge unit
// one item at a time; the result waits in an output register
// synchronous active high reset empties the polygon and clears overflow
`timescale 1ns / 1ps
`include "point_in_polygon_test_top_defines.svh"
module point_in_polygon_test_top #(
  parameter int MAX_VERTICES = 64,
  parameter int COORD_WIDTH  = 16
) (
  input logic clk,
  input logic rst,
  pip_in_if.sink    in_ch,
  pip_out_if.source out_ch
);
  import pip_pkg::*;
  localparam int CW = $clog2(MAX_VERTICES + 1);

  state_t                        state, state_next;
  logic [CW-1:0]                 vcount;   // live vertices
  logic [CW-1:0]                 k;        // walk position
  logic                          drain;
  logic                          overflow;
  logic signed [COORD_WIDTH-1:0] px, py;
  edge_ctl_t                     ctl;
  logic                          shift, load_out, in_fire, append_en;
  logic                          parity, hit;

  logic signed [COORD_WIDTH-1:0] cell_x [MAX_VERTICES];
  logic signed [COORD_WIDTH-1:0] cell_y [MAX_VERTICES];

  assign in_fire   = in_ch.valid && in_ch.ready;
  assign append_en = in_fire && in_ch.command == CMD_APPEND;

  // vertex ring: slot 0 is the head seen by the edge unit
  for (genvar g = 0; g < MAX_VERTICES; g++) begin : g_cell
    localparam int NB = (g == MAX_VERTICES - 1) ? 0 : g + 1;
    pip_cell #(.COORD_WIDTH(COORD_WIDTH)) u_cell (
      .clk   (clk),
      .we    (append_en && vcount == CW'(g)),
      .shift (shift),
      .wrap  (vcount == CW'(g + 1)),
      .wx    (in_ch.coord_x),
      .wy    (in_ch.coord_y),
      .nx    (cell_x[NB]),
      .ny    (cell_y[NB]),
      .fx    (cell_x[0]),
      .fy    (cell_y[0]),
      .x     (cell_x[g]),
      .y     (cell_y[g])
    );
  end

  pip_edge #(.COORD_WIDTH(COORD_WIDTH)) u_edge (
    .clk    (clk),
    .ctl    (ctl),
    .px     (px),
    .py     (py),
    .cx     (cell_x[0]),
    .cy     (cell_y[0]),
    .parity (parity),
    .hit    (hit)
  );

  always_ff @(posedge clk) begin
    if (rst) state <= ST_IDLE;
    else     state <= state_next;
  end

  // sequencer
  always_comb begin
    state_next  = state;
    in_ch.ready = 1'b0;
    ctl         = '0;
    shift       = 1'b0;
    load_out    = 1'b0;
    unique case (state)
      ST_IDLE: begin
        in_ch.ready = 1'b1;
        if (in_ch.valid && in_ch.command == CMD_QUERY) begin
          ctl.start  = 1'b1;
          state_next = ST_WALK;
        end
      end
      ST_WALK: begin
        if (k < vcount) begin
          shift          = 1'b1;
          ctl.take       = 1'b1;
          ctl.first_take = (k == '0);
        end else begin
          // closing edge from last vertex back to first
          ctl.close  = (vcount != '0);
          state_next = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        if (drain) state_next = ST_FINISH;
      end
      ST_FINISH: begin
        if (!out_ch.valid || out_ch.ready) begin
          load_out   = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (ctl.start) begin
      px <= in_ch.coord_x;
      py <= in_ch.coord_y;
    end
    if (ctl.start)  k <= '0;
    else if (shift) k <= k + 1'b1;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vcount   <= '0;
      overflow <= 1'b0;
      drain    <= 1'b0;
    end else begin
      drain <= (state == ST_DRAIN) && !drain;
      if (in_fire && in_ch.command == CMD_CLEAR) begin
        vcount   <= '0;
        overflow <= 1'b0;
      end else if (append_en) begin
        if (vcount < CW'(MAX_VERTICES)) vcount <= vcount + 1'b1;
        else                            overflow <= 1'b1;
      end
    end
  end

  // result register, frees the walk while an item waits downstream
  always_ff @(posedge clk) begin
    if (rst) begin
      out_ch.valid <= 1'b0;
    end else if (load_out) begin
      out_ch.valid <= 1'b1;
    end else if (out_ch.ready) begin
      out_ch.valid <= 1'b0;
    end
    if (load_out) begin
      out_ch.inside_res <= parity && !hit;
      out_ch.on_vertex  <= hit;
      out_ch.overflowed <= overflow;
    end
  end

  `PIP_ASSERT(a_count_cap, clk, rst, vcount <= CW'(MAX_VERTICES))
  `PIP_ASSERT(a_ovf_full, clk, rst, overflow |-> vcount == CW'(MAX_VERTICES))
  `PIP_ASSERT(a_walk_bound, clk, rst, (state == ST_WALK) |-> k <= vcount)
  `PIP_ASSERT(a_out_src, clk, rst, $rose(out_ch.valid) |-> $past(state) == ST_FINISH)
endmodule
